// ----- rtl/core/sbsdf_pkg.sv -----
// sbsdf_pkg: shared widths, fixed-point shape constants and types for the socket base sdf
// depends on nothing; imported by every module of the block
`default_nettype none

package sbsdf_pkg;

    localparam int FRAC_BITS = 24;

    // coordinate, length and square-root widths
    localparam int PW       = 32;            // input coordinate width
    localparam int LW       = 34;            // signed width of intermediate lengths
    localparam int CW       = 32;            // clamped length component width
    localparam int SW       = 64;            // sum of squares width
    localparam int RW       = 34;            // rounded root width
    localparam int DW       = 36;            // signed width of part distances
    localparam int SQ_STEPS = SW / 2;        // one cell per root bit
    localparam int LANES    = 3;             // top box or engaged x, engaged y, bottom
    localparam int FRONT_STAGES = 4;

    // fixed-point constants, round to nearest with halves up
    localparam longint ONE        = 64'sd1 <<< FRAC_BITS;
    localparam longint K_BOT_XY   = (ONE * 5 + 50) / 100;
    localparam longint K_BOT_Z    = (ONE * 1 + 50) / 100;
    localparam longint K_TOP_HALF = (ONE * 175 + 5000) / 10000;
    localparam longint K_TOP_Z    = (ONE * 25 + 500) / 1000;
    localparam longint K_INSET    = (ONE * 5 + 500) / 1000;
    localparam longint K_TOP_OFS  = 2 * K_BOT_Z + K_TOP_Z;

    localparam logic signed [LW-1:0] C_BOT_XY   = LW'(K_BOT_XY);
    localparam logic signed [LW-1:0] C_BOT_Z    = LW'(K_BOT_Z);
    localparam logic signed [LW-1:0] C_TOP_HALF = LW'(K_TOP_HALF);
    localparam logic signed [LW-1:0] C_TOP_Z    = LW'(K_TOP_Z);
    localparam logic signed [LW-1:0] C_INSET    = LW'(K_INSET);
    localparam logic signed [LW-1:0] C_TOP_OFS  = LW'(K_TOP_OFS);
    localparam logic signed [LW-1:0] C_CLAMP    = LW'(64'sd1 <<< (PW - 1));

    localparam logic signed [DW-1:0] D_MAX = DW'(64'sd2147483647);
    localparam logic signed [DW-1:0] D_MIN = -DW'(64'sd2147483648);

    typedef enum logic [1:0] {
        TOP_INSERTED,
        TOP_ENGAGED,
        TOP_BOX
    } top_mode_t;

    // data that travels beside the square-root lanes
    typedef struct packed {
        top_mode_t              mode;
        logic signed [LW-1:0]   top_inside;
        logic signed [LW-1:0]   top_alt;
        logic signed [LW-1:0]   bot_inside;
    } side_t;

endpackage

`default_nettype wire

// ----- rtl/core/sbsdf_front.sv -----
// sbsdf_front: folds the query point into the shape's frame, picks the top case,
// clamps the length components, squares and sums them; uses sbsdf_pkg
`default_nettype none

module sbsdf_front (
    input  wire logic                                        aclk,
    input  wire logic                                        en,
    input  wire logic signed [sbsdf_pkg::PW-1:0]             point_x,
    input  wire logic signed [sbsdf_pkg::PW-1:0]             point_y,
    input  wire logic signed [sbsdf_pkg::PW-1:0]             point_z,
    input  wire logic [23:0]                                 gap_width,
    output logic [sbsdf_pkg::LANES-1:0][sbsdf_pkg::SW-1:0]   sum_sq,
    output sbsdf_pkg::side_t                                 side
);
    import sbsdf_pkg::*;

    // clamp a length component to [0, 2^31]
    function automatic logic [CW-1:0] clamp_len(input logic signed [LW-1:0] v);
        logic [CW-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > C_CLAMP) begin
            res = CW'(C_CLAMP);
        end else begin
            res = CW'(v);
        end
        return res;
    endfunction

    function automatic logic signed [LW-1:0] min2(input logic signed [LW-1:0] a,
                                                  input logic signed [LW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [LW-1:0] max2(input logic signed [LW-1:0] a,
                                                  input logic signed [LW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // stage 1: absolute coordinates
    logic [PW:0]          ax_reg, ay_reg, azt_reg, azb_reg;
    logic signed [PW:0]   zt, zb;

    always_comb begin
        zt = (PW+1)'(point_z) - (PW+1)'(C_TOP_OFS);
        zb = (PW+1)'(point_z) - (PW+1)'(C_BOT_Z);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ax_reg  <= point_x[PW-1] ? -{point_x[PW-1], point_x} : {point_x[PW-1], point_x};
            ay_reg  <= point_y[PW-1] ? -{point_y[PW-1], point_y} : {point_y[PW-1], point_y};
            azt_reg <= zt[PW] ? -zt : zt;
            azb_reg <= zb[PW] ? -zb : zb;
        end
    end

    // stage 2: case selection and length components
    logic signed [LW-1:0] ax, ay, azt, azb, half, inset;
    logic signed [LW-1:0] q0, q1, q2, e0, e1, b0, b1, b2, ins_min;
    logic                 in_foot, inserted;
    logic [LANES-1:0][2:0][CW-1:0] comp_next;
    logic [LANES-1:0][2:0][CW-1:0] comp_reg;
    side_t                side_next, side2_reg, side3_reg, side4_reg;

    always_comb begin
        ax    = LW'(ax_reg);
        ay    = LW'(ay_reg);
        azt   = LW'(azt_reg);
        azb   = LW'(azb_reg);
        half  = C_TOP_HALF + LW'(gap_width);
        inset = half - C_INSET;
        q0    = ax - half;
        q1    = ay - half;
        q2    = azt - C_TOP_Z;
        e0    = inset - ax;
        e1    = inset - ay;
        b0    = ax - C_BOT_XY;
        b1    = ay - C_BOT_XY;
        b2    = azb - C_BOT_Z;
        in_foot  = (ax <= inset) && (ay <= inset);
        inserted = in_foot && (azt <= C_TOP_Z);
        ins_min  = min2(e0, min2(e1, azt));

        side_next.top_inside = min2(max2(q0, max2(q1, q2)), '0);
        side_next.bot_inside = min2(max2(b0, max2(b1, b2)), '0);
        side_next.top_alt    = inserted ? ins_min : azt;
        if (inserted) begin
            side_next.mode = TOP_INSERTED;
        end else if (in_foot) begin
            side_next.mode = TOP_ENGAGED;
        end else begin
            side_next.mode = TOP_BOX;
        end

        // lane 0 serves the top box or the engaged x edge
        if (in_foot) begin
            comp_next[0] = {clamp_len(e0), CW'(0), clamp_len(q2)};
        end else begin
            comp_next[0] = {clamp_len(q0), clamp_len(q1), clamp_len(q2)};
        end
        comp_next[1] = {clamp_len(e1), CW'(0), clamp_len(q2)};
        comp_next[2] = {clamp_len(b0), clamp_len(b1), clamp_len(b2)};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            comp_reg  <= comp_next;
            side2_reg <= side_next;
        end
    end

    // stage 3: squares
    logic [LANES-1:0][2:0][SW-1:0] sq_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                for (int c = 0; c < 3; c++) begin
                    sq_reg[l][c] <= SW'(comp_reg[l][c]) * SW'(comp_reg[l][c]);
                end
            end
            side3_reg <= side2_reg;
        end
    end

    // stage 4: sums of squares
    logic [LANES-1:0][SW-1:0] sum_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                sum_reg[l] <= sq_reg[l][0] + sq_reg[l][1] + sq_reg[l][2];
            end
            side4_reg <= side3_reg;
        end
    end

    assign sum_sq = sum_reg;
    assign side   = side4_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sbsdf_sqrt_cell.sv -----
// sbsdf_sqrt_cell: one restoring step of the integer square root, two radicand bits
// per cell; uses sbsdf_pkg
`default_nettype none

module sbsdf_sqrt_cell (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic [sbsdf_pkg::SW-1:0] bit_val,
    input  wire logic [sbsdf_pkg::SW-1:0] rem_in,
    input  wire logic [sbsdf_pkg::SW-1:0] root_in,
    output logic [sbsdf_pkg::SW-1:0]      rem_out,
    output logic [sbsdf_pkg::SW-1:0]      root_out
);
    import sbsdf_pkg::*;

    logic [SW-1:0] trial;
    logic [SW-1:0] rem_next, root_next;
    logic [SW-1:0] rem_reg, root_reg;

    // try to take the next root bit
    always_comb begin
        trial = root_in + bit_val;
        if (rem_in >= trial) begin
            rem_next  = rem_in - trial;
            root_next = (root_in >> 1) + bit_val;
        end else begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sbsdf_back.sv -----
// sbsdf_back: rounds the three roots, forms top and bottom distances, takes the
// minimum and saturates into the output register; uses sbsdf_pkg
`default_nettype none

module sbsdf_back (
    input  wire logic                                        aclk,
    input  wire logic                                        en,
    input  wire logic [sbsdf_pkg::LANES-1:0][sbsdf_pkg::SW-1:0] rem_in,
    input  wire logic [sbsdf_pkg::LANES-1:0][sbsdf_pkg::SW-1:0] root_in,
    input  wire sbsdf_pkg::side_t                            side_in,
    output logic signed [sbsdf_pkg::PW-1:0]                  signed_distance
);
    import sbsdf_pkg::*;

    // round to nearest, ties down
    logic [LANES-1:0][RW-1:0] rnd_reg;
    side_t                    side_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                rnd_reg[l] <= RW'(root_in[l]) + RW'(rem_in[l] > root_in[l]);
            end
            side_reg <= side_in;
        end
    end

    // top and bottom part distances
    logic signed [DW-1:0] ra, rb, rc, alt, top_next, bot_next, top_reg, bot_reg;

    always_comb begin
        ra  = DW'(rnd_reg[0]);
        rb  = DW'(rnd_reg[1]);
        rc  = DW'(rnd_reg[2]);
        alt = DW'(side_reg.top_alt);
        unique case (side_reg.mode)
            TOP_INSERTED: begin
                top_next = alt;
            end
            TOP_ENGAGED: begin
                top_next = (ra < rb) ? ra : rb;
                if (alt < top_next) begin
                    top_next = alt;
                end
            end
            TOP_BOX: begin
                top_next = ra + DW'(side_reg.top_inside);
            end
            default: begin
                top_next = ra + DW'(side_reg.top_inside);
            end
        endcase
        bot_next = rc + DW'(side_reg.bot_inside);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            top_reg <= top_next;
            bot_reg <= bot_next;
        end
    end

    // minimum and saturation
    logic signed [DW-1:0] dmin;
    logic signed [PW-1:0] dist_next, dist_reg;

    always_comb begin
        dmin = (top_reg < bot_reg) ? top_reg : bot_reg;
        if (dmin > D_MAX) begin
            dist_next = PW'(D_MAX);
        end else if (dmin < D_MIN) begin
            dist_next = PW'(D_MIN);
        end else begin
            dist_next = PW'(dmin);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dist_reg <= dist_next;
        end
    end

    assign signed_distance = dist_reg;

endmodule

`default_nettype wire

// ----- rtl/core/socket_base_sdf_distance_top.sv -----
// socket_base_sdf_distance_top: signed distance from a query point to the socket base
// one item per cycle sustained while the output register is free or being emptied
// the whole pipeline, 32 square-root cells per lane, moves as one on a free output register
// synchronous active-low reset clears valid flags and the gap register to zero
// depends on sbsdf_pkg, sbsdf_front, sbsdf_sqrt_cell, sbsdf_back
`default_nettype none

module socket_base_sdf_distance_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [sbsdf_pkg::PW-1:0]    s_point_x,
    input  wire logic signed [sbsdf_pkg::PW-1:0]    s_point_y,
    input  wire logic signed [sbsdf_pkg::PW-1:0]    s_point_z,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [sbsdf_pkg::PW-1:0]         m_signed_distance,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [23:0]                        cfg_data
);
    import sbsdf_pkg::*;

    localparam int NSTG = FRONT_STAGES + SQ_STEPS + 2;

    logic            en;
    logic [23:0]     gap_reg;
    logic [NSTG-1:0] vld_reg;
    logic            m_valid_reg;

    // pipeline moves whenever the output register is free or being emptied
    assign en        = m_ready || !m_valid_reg;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;

    // gap register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gap_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            gap_reg <= cfg_data;
        end
    end

    // valid flags along the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[NSTG-2:0], s_valid};
            m_valid_reg <= vld_reg[NSTG-1];
        end
    end

    // front end
    logic [LANES-1:0][SW-1:0] sum_sq;
    side_t                    front_side;

    sbsdf_front u_front (
        .aclk      (aclk),
        .en        (en),
        .point_x   (s_point_x),
        .point_y   (s_point_y),
        .point_z   (s_point_z),
        .gap_width (gap_reg),
        .sum_sq    (sum_sq),
        .side      (front_side)
    );

    // chain of square-root cells, three lanes
    logic [LANES-1:0][SW-1:0] rem_w  [SQ_STEPS+1];
    logic [LANES-1:0][SW-1:0] root_w [SQ_STEPS+1];

    assign rem_w[0]  = sum_sq;
    assign root_w[0] = '0;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            sbsdf_sqrt_cell u_cell (
                .aclk     (aclk),
                .en       (en),
                .bit_val  (SW'(1) << (2 * (SQ_STEPS - 1 - k))),
                .rem_in   (rem_w[k][l]),
                .root_in  (root_w[k][l]),
                .rem_out  (rem_w[k+1][l]),
                .root_out (root_w[k+1][l])
            );
        end
    end

    // side data delayed alongside the cells
    side_t side_reg [SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= front_side;
            for (int k = 1; k < SQ_STEPS; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // back end
    sbsdf_back u_back (
        .aclk            (aclk),
        .en              (en),
        .rem_in          (rem_w[SQ_STEPS]),
        .root_in         (root_w[SQ_STEPS]),
        .side_in         (side_reg[SQ_STEPS-1]),
        .signed_distance (m_signed_distance)
    );

    // checks
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_last_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        en |=> m_valid == $past(vld_reg[NSTG-1]))
        else $error("last stage item not moved into output register");

endmodule

`default_nettype wire
